// ----- design/yr2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yr2rgb_pkg
// Shared constants and codes for the rotating YUV 4:2:0 to RGB block: field
// widths, register indexes, rotation codes and register reset values.
// ----------------------------------------------------------------------------
package yr2rgb_pkg;

  localparam int unsigned CoordBits     = 12;
  localparam int unsigned AddrBits      = 26;
  localparam int unsigned DimBits       = 13;
  localparam int unsigned StrideBits    = 16;
  localparam int unsigned PixStrideBits = 4;
  localparam int unsigned LenBits       = 26;
  localparam int unsigned RotBits       = 2;
  localparam int unsigned CfgIdxBits    = 8;
  localparam int unsigned CfgDataBits   = 32;

  typedef enum logic [2:0] {
    CfgRotation     = 3'd0,
    CfgSrcWidth     = 3'd1,
    CfgSrcHeight    = 3'd2,
    CfgLumaStride   = 3'd3,
    CfgChromaStride = 3'd4,
    CfgChromaPixStr = 3'd5,
    CfgLumaLength   = 3'd6,
    CfgChromaLength = 3'd7
  } cfg_idx_e;

  typedef enum logic [RotBits-1:0] {
    RotNone = 2'd0,
    Rot90   = 2'd1,
    Rot180  = 2'd2,
    Rot270  = 2'd3
  } rot_e;

  localparam logic ReqAddress = 1'b0;
  localparam logic ReqConvert = 1'b1;

  localparam logic [DimBits-1:0]       RstSrcWidth     = 13'd640;
  localparam logic [DimBits-1:0]       RstSrcHeight    = 13'd480;
  localparam logic [StrideBits-1:0]    RstLumaStride   = 16'd640;
  localparam logic [StrideBits-1:0]    RstChromaStride = 16'd640;
  localparam logic [PixStrideBits-1:0] RstChromaPixStr = 4'd2;
  localparam logic [LenBits-1:0]       RstLumaLength   = 26'd307200;
  localparam logic [LenBits-1:0]       RstChromaLength = 26'd153600;

endpackage

// ----- design/yuv420_rotate_to_rgb.sv -----
// ----------------------------------------------------------------------------
// yuv420_rotate_to_rgb
// Rotates a destination pixel into source luma and chroma byte addresses, or
// converts one Y/Cb/Cr sample to clamped BT.601 video-range RGB.
// Path: an accepted input is held in the input register, then the result
// register. Throughput: one item per cycle while the output is not stalled;
// the single multiply-add stage between the two registers sets this figure.
// Reset: the control state clears and the configuration registers return to
// a 640 by 480 frame with no rotation.
// ----------------------------------------------------------------------------
module yuv420_rotate_to_rgb (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [yr2rgb_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [yr2rgb_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    req_type_i,
  input  logic [yr2rgb_pkg::CoordBits-1:0]        dest_x_i,
  input  logic [yr2rgb_pkg::CoordBits-1:0]        dest_y_i,
  input  logic [7:0]                              luma_i,
  input  logic [7:0]                              chroma_blue_i,
  input  logic [7:0]                              chroma_red_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [yr2rgb_pkg::AddrBits-1:0]         luma_address_o,
  output logic [yr2rgb_pkg::AddrBits-1:0]         chroma_address_o,
  output logic [7:0]                              red_o,
  output logic [7:0]                              green_o,
  output logic [7:0]                              blue_o,
  output logic                                    geometry_bad_o,
  output logic                                    coordinate_bad_o
);

  localparam int unsigned DimW   = yr2rgb_pkg::DimBits;
  localparam int unsigned CoordW = yr2rgb_pkg::CoordBits;
  localparam int unsigned CmpW   = (CoordW > DimW) ? CoordW : DimW;
  localparam int unsigned SumW   = DimW + yr2rgb_pkg::StrideBits + 1;
  localparam int unsigned AddrW  = (SumW > yr2rgb_pkg::AddrBits) ? SumW
                                                                   : yr2rgb_pkg::AddrBits;
  localparam int unsigned LumaLastW   = DimW + yr2rgb_pkg::StrideBits + 1;
  localparam int unsigned ChromaLastW = DimW + yr2rgb_pkg::StrideBits;

  // Configuration registers.
  yr2rgb_pkg::rot_e                        rot_q;
  logic [DimW-1:0]                         width_q;
  logic [DimW-1:0]                         height_q;
  logic [yr2rgb_pkg::StrideBits-1:0]       luma_stride_q;
  logic [yr2rgb_pkg::StrideBits-1:0]       chroma_stride_q;
  logic [yr2rgb_pkg::PixStrideBits-1:0]    chroma_pix_q;
  logic [yr2rgb_pkg::LenBits-1:0]          luma_len_q;
  logic [yr2rgb_pkg::LenBits-1:0]          chroma_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q           <= yr2rgb_pkg::RotNone;
      width_q         <= yr2rgb_pkg::RstSrcWidth;
      height_q        <= yr2rgb_pkg::RstSrcHeight;
      luma_stride_q   <= yr2rgb_pkg::RstLumaStride;
      chroma_stride_q <= yr2rgb_pkg::RstChromaStride;
      chroma_pix_q    <= yr2rgb_pkg::RstChromaPixStr;
      luma_len_q      <= yr2rgb_pkg::RstLumaLength;
      chroma_len_q    <= yr2rgb_pkg::RstChromaLength;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i[yr2rgb_pkg::CfgIdxBits-1:3] == '0)) begin
      unique case (yr2rgb_pkg::cfg_idx_e'(cfg_index_i[2:0]))
        yr2rgb_pkg::CfgRotation: begin
          rot_q <= yr2rgb_pkg::rot_e'(cfg_data_i[yr2rgb_pkg::RotBits-1:0]);
        end
        yr2rgb_pkg::CfgSrcWidth:     width_q <= cfg_data_i[DimW-1:0];
        yr2rgb_pkg::CfgSrcHeight:    height_q <= cfg_data_i[DimW-1:0];
        yr2rgb_pkg::CfgLumaStride:   luma_stride_q <= cfg_data_i[yr2rgb_pkg::StrideBits-1:0];
        yr2rgb_pkg::CfgChromaStride: chroma_stride_q <= cfg_data_i[yr2rgb_pkg::StrideBits-1:0];
        yr2rgb_pkg::CfgChromaPixStr: chroma_pix_q <= cfg_data_i[yr2rgb_pkg::PixStrideBits-1:0];
        yr2rgb_pkg::CfgLumaLength:   luma_len_q <= cfg_data_i[yr2rgb_pkg::LenBits-1:0];
        yr2rgb_pkg::CfgChromaLength: chroma_len_q <= cfg_data_i[yr2rgb_pkg::LenBits-1:0];
        default: ;
      endcase
    end
  end

  // Frame geometry products, refreshed every cycle from the registers.
  logic                      geo_small_d, geo_small_q;
  logic [LumaLastW-1:0]      luma_last_d, luma_last_q;
  logic [ChromaLastW-1:0]    chroma_last_d, chroma_last_q;
  logic [DimW-2:0]           half_w_m1, half_h_m1;

  always_comb begin
    geo_small_d   = (width_q < DimW'(2)) || (height_q < DimW'(2));
    half_w_m1     = width_q[DimW-1:1] - (DimW-1)'(1);
    half_h_m1     = height_q[DimW-1:1] - (DimW-1)'(1);
    luma_last_d   = LumaLastW'(height_q - DimW'(1)) * LumaLastW'(luma_stride_q)
                  + LumaLastW'(width_q - DimW'(1));
    chroma_last_d = ChromaLastW'(half_h_m1) * ChromaLastW'(chroma_stride_q)
                  + ChromaLastW'(half_w_m1) * ChromaLastW'(chroma_pix_q);
  end

  always_ff @(posedge clk_i) begin
    geo_small_q   <= geo_small_d;
    luma_last_q   <= luma_last_d;
    chroma_last_q <= chroma_last_d;
  end

  // Handshake and pipeline control.
  logic s1_valid_q, out_valid_q;
  logic advance, in_accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Rotation into a source coordinate and the coordinate check.
  logic [CmpW-1:0] dx, dy, dst_w, dst_h, w_m1, h_m1;
  logic [CmpW-1:0] sx_full, sy_full;
  logic            quarter, coord_bad_d;

  always_comb begin
    dx      = CmpW'(dest_x_i);
    dy      = CmpW'(dest_y_i);
    w_m1    = CmpW'(width_q) - CmpW'(1);
    h_m1    = CmpW'(height_q) - CmpW'(1);
    quarter = (rot_q == yr2rgb_pkg::Rot90) || (rot_q == yr2rgb_pkg::Rot270);
    dst_w   = quarter ? CmpW'(height_q) : CmpW'(width_q);
    dst_h   = quarter ? CmpW'(width_q) : CmpW'(height_q);
    coord_bad_d = (dx >= dst_w) || (dy >= dst_h);
    unique case (rot_q)
      yr2rgb_pkg::Rot90: begin
        sx_full = dy;
        sy_full = h_m1 - dx;
      end
      yr2rgb_pkg::Rot180: begin
        sx_full = w_m1 - dx;
        sy_full = h_m1 - dy;
      end
      yr2rgb_pkg::Rot270: begin
        sx_full = w_m1 - dy;
        sy_full = dx;
      end
      default: begin
        sx_full = dx;
        sy_full = dy;
      end
    endcase
  end

  // Input register.
  logic            s1_req_q, s1_coord_bad_q;
  logic [DimW-1:0] s1_sx_q, s1_sy_q;
  logic [7:0]      s1_luma_q, s1_cb_q, s1_cr_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q       <= req_type_i;
      s1_coord_bad_q <= coord_bad_d;
      s1_sx_q        <= sx_full[DimW-1:0];
      s1_sy_q        <= sy_full[DimW-1:0];
      s1_luma_q      <= luma_i;
      s1_cb_q        <= chroma_blue_i;
      s1_cr_q        <= chroma_red_i;
    end
  end

  // Address arithmetic.
  logic            geo_bad;
  logic [SumW-1:0] luma_sum, chroma_sum;
  logic [AddrW-1:0] luma_full, chroma_full;

  always_comb begin
    geo_bad = geo_small_q
           || (luma_last_q >= LumaLastW'(luma_len_q))
           || (ChromaLastW'(chroma_last_q) >= ChromaLastW'(chroma_len_q));
    luma_sum   = SumW'(s1_sy_q) * SumW'(luma_stride_q) + SumW'(s1_sx_q);
    chroma_sum = SumW'(s1_sy_q[DimW-1:1]) * SumW'(chroma_stride_q)
               + SumW'(s1_sx_q[DimW-1:1]) * SumW'(chroma_pix_q);
    luma_full   = AddrW'(luma_sum);
    chroma_full = AddrW'(chroma_sum);
  end

  // Color conversion in 10-bit fixed point; the arithmetic shift floors.
  logic signed [9:0]  ym;
  logic signed [8:0]  cb_m, cr_m;
  logic signed [21:0] cy, r_sum, g_sum, b_sum;
  logic signed [11:0] r_sh, g_sh, b_sh;
  logic [7:0]         r_sat, g_sat, b_sat;

  always_comb begin
    ym    = $signed({2'b00, s1_luma_q}) - 10'sd16;
    cb_m  = $signed({1'b0, s1_cb_q}) - 9'sd128;
    cr_m  = $signed({1'b0, s1_cr_q}) - 9'sd128;
    cy    = 22'(ym) * 22'sd1192;
    r_sum = cy + 22'(cr_m) * 22'sd1634;
    g_sum = cy - 22'(cb_m) * 22'sd401 - 22'(cr_m) * 22'sd832;
    b_sum = cy + 22'(cb_m) * 22'sd2066;
    r_sh  = 12'(r_sum >>> 10);
    g_sh  = 12'(g_sum >>> 10);
    b_sh  = 12'(b_sum >>> 10);
    r_sat = r_sh[11] ? 8'd0 : ((r_sh[10:8] != 3'd0) ? 8'd255 : r_sh[7:0]);
    g_sat = g_sh[11] ? 8'd0 : ((g_sh[10:8] != 3'd0) ? 8'd255 : g_sh[7:0]);
    b_sat = b_sh[11] ? 8'd0 : ((b_sh[10:8] != 3'd0) ? 8'd255 : b_sh[7:0]);
  end

  // Result register.
  logic [yr2rgb_pkg::AddrBits-1:0] luma_addr_q, chroma_addr_q;
  logic [7:0]                      red_q, green_q, blue_q;
  logic                            geo_bad_q, coord_bad_q;
  logic                            addr_ok;

  assign addr_ok = (s1_req_q == yr2rgb_pkg::ReqAddress) && !s1_coord_bad_q && !geo_bad;

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      luma_addr_q   <= addr_ok ? luma_full[yr2rgb_pkg::AddrBits-1:0] : '0;
      chroma_addr_q <= addr_ok ? chroma_full[yr2rgb_pkg::AddrBits-1:0] : '0;
      red_q         <= (s1_req_q == yr2rgb_pkg::ReqConvert) ? r_sat : 8'd0;
      green_q       <= (s1_req_q == yr2rgb_pkg::ReqConvert) ? g_sat : 8'd0;
      blue_q        <= (s1_req_q == yr2rgb_pkg::ReqConvert) ? b_sat : 8'd0;
      geo_bad_q     <= geo_bad;
      coord_bad_q   <= (s1_req_q == yr2rgb_pkg::ReqAddress) && s1_coord_bad_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign luma_address_o   = luma_addr_q;
  assign chroma_address_o = chroma_addr_q;
  assign red_o            = red_q;
  assign green_o          = green_q;
  assign blue_o           = blue_q;
  assign geometry_bad_o   = geo_bad_q;
  assign coordinate_bad_o = coord_bad_q;

endmodule
